@@ rtl/rll_pkg.sv @@
package rll_pkg;

	localparam int DEF_ENTRIES = 16;
	localparam int CNT_W = 63;
	localparam int DW = 64;
	localparam int IN_TDATA_W = 136;
	localparam int OUT_TDATA_W = 200;

	localparam logic [3:0] MODE_CREDIT = 4'd0;
	localparam logic [3:0] MODE_DEBIT = 4'd1;
	localparam logic [3:0] MODE_SET_LIMIT = 4'd2;
	localparam logic [3:0] MODE_SET_PERIOD = 4'd3;
	localparam logic [3:0] MODE_SET_ACTION = 4'd4;
	localparam logic [3:0] MODE_CB_OFF = 4'd5;
	localparam logic [3:0] MODE_CB_REARM = 4'd6;
	localparam logic [3:0] MODE_SCAN = 4'd7;
	localparam logic [3:0] MODE_READ = 4'd8;

	localparam int FL_ACTIVE = 0;
	localparam int FL_BLOCK = 1;
	localparam int FL_CALLBACK = 2;
	localparam int FL_WAKE = 3;
	localparam int FL_CALLED = 4;

	typedef struct packed {
		logic [CNT_W-1:0] credit;
		logic [CNT_W-1:0] debit;
		logic signed [DW-1:0] limit;
		logic [DW-1:0] period;
		logic [DW-1:0] last;
		logic [4:0] flags;
	} entry_t;

	localparam entry_t RESET_REC = '{
		credit: '0,
		debit: '0,
		limit: {1'b0, {(DW-1){1'b1}}},
		period: '0,
		last: '0,
		flags: 5'b00001
	};

	function automatic logic signed [DW-1:0] bal_of(entry_t r);
		bal_of = signed'({1'b0, r.credit}) - signed'({1'b0, r.debit});
	endfunction

	function automatic logic exceeded(entry_t r);
		logic signed [DW-1:0] b;
		b = bal_of(r);
		if (r.limit <= 0) begin
			exceeded = b < r.limit;
		end else begin
			exceeded = b > r.limit;
		end
	endfunction

endpackage

@@ rtl/rll_mem.sv @@
module rll_mem #(
	parameter int ENTRIES = 16,
	parameter int IDX_W = 4
) (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [IDX_W-1:0] rd_addr,
	output rll_pkg::entry_t rd_data,
	input logic wr_en,
	input logic [IDX_W-1:0] wr_addr,
	input rll_pkg::entry_t wr_data
);
	import rll_pkg::*;

	entry_t mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	entry_t rdat_q;
	logic rvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdat_q <= mem[rd_addr];
		end
	end

	assign rd_data = rvld_q ? rdat_q : RESET_REC;

endmodule

@@ rtl/rll_div.sv @@
module rll_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [rll_pkg::DW-1:0] dividend,
	input logic [rll_pkg::DW-1:0] divisor,
	output logic done,
	output logic [rll_pkg::DW-1:0] quotient,
	output logic [rll_pkg::DW-1:0] remainder
);
	import rll_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DW-1:0] q_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [DW:0] trial;
	logic take;

	assign trial = {r_q, q_q[DW-1]};
	assign take = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DW-2:0], take};
			r_q <= take ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quotient = q_q;
	assign remainder = r_q;

endmodule

@@ rtl/rll_mul.sv @@
module rll_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [rll_pkg::DW-1:0] mplier,
	input logic [rll_pkg::DW-1:0] mcand,
	output logic done,
	output logic [rll_pkg::DW:0] product
);
	import rll_pkg::*;

	localparam int CW = $clog2(DW + 1);
	localparam logic [DW:0] SAT = {1'b1, {DW{1'b0}}};

	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DW-1:0] a_q;
	logic [DW-1:0] m_q;
	logic [DW:0] acc_q;
	logic [DW+2:0] nxt;

	assign nxt = {1'b0, acc_q, 1'b0} + (a_q[DW-1] ? (DW+3)'(m_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// saturate at 2^64, enough for every compare downstream
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= mplier;
			m_q <= mcand;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[DW-2:0], 1'b0};
			acc_q <= (nxt >= (DW+3)'(SAT)) ? SAT : nxt[DW:0];
		end
	end

	assign done = done_q;
	assign product = acc_q;

endmodule

@@ rtl/resource_ledger_limit_refill.sv @@
// channel  dir  tdata (low bit up)                         tuser
// s_*      in   entry[3:0] value[67:4] now[131:68] pad     mode[3:0]
// m_*      out  status over_limit notice wake fire_callback -
//               block_needed balance[69:6] credit_total[132:70]
//               debit_total[195:133] pad
// A transaction without a refill runs the read, evaluate, post and final states.
// A refill adds a 64-step divider pass, a 64-step multiplier pass and a refill
// state between evaluate and post.
// One transaction is in flight; the next is accepted once the result is registered.
// Reset clears control and marks every entry as holding its reset value.
// A stalled m_tready holds the result and the sequencer in its final state.
module resource_ledger_limit_refill #(
	parameter int ENTRIES = rll_pkg::DEF_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [rll_pkg::IN_TDATA_W-1:0] s_tdata, // entry, value, now
	input logic [3:0] s_tuser, // mode
	output logic m_tvalid,
	input logic m_tready,
	output logic [rll_pkg::OUT_TDATA_W-1:0] m_tdata // status..debit_total
);
	import rll_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_MUL = 3'd4;
	localparam logic [2:0] ST_REF = 3'd5;
	localparam logic [2:0] ST_POST = 3'd6;
	localparam logic [2:0] ST_FIN = 3'd7;

	logic [2:0] state_q;
	logic [3:0] mode_q;
	logic [3:0] entry_q;
	logic signed [DW-1:0] value_q;
	logic [DW-1:0] now_q;
	entry_t rec_q;
	logic st_q, notice_q, woke_q, fire_q, blk_q;
	logic acct_q, lwake_q, scan_q;
	logic [CNT_W-1:0] ct_q, dt_q;
	logic m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	entry_t rd_data;
	logic rd_en, wr_en;
	logic [IDX_W-1:0] addr;
	logic [IDX_W-1:0] rd_addr;
	logic in_acc, oor;

	logic div_start, div_done, mul_start, mul_done;
	logic [DW-1:0] quo, rem;
	logic [DW:0] prod;
	logic [DW-1:0] el;
	logic [DW-1:0] mcand;

	entry_t ev_rec;
	logic ev_st, ev_acct, ev_lwake, ev_scan, ev_refill;
	logic [CNT_W-1:0] ev_ct, ev_dt;
	entry_t rf_rec;
	logic rf_woke;
	entry_t po_rec;
	logic po_notice, po_woke, po_fire, po_blk;

	assign in_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign oor = 32'(s_tdata[3:0]) >= 32'(ENTRIES);
	assign addr = IDX_W'(entry_q);
	assign rd_addr = IDX_W'(s_tdata[3:0]);
	assign rd_en = in_acc && !oor;
	assign wr_en = (state_q == ST_POST);
	assign el = now_q - rec_q.last;
	assign mcand = rec_q.limit[DW-1] ? DW'(0) - DW'(rec_q.limit) : DW'(rec_q.limit);

	rll_mem #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(addr),
		.wr_data(po_rec)
	);

	rll_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(el),
		.divisor(rec_q.period),
		.done(div_done),
		.quotient(quo),
		.remainder(rem)
	);

	rll_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.mplier(quo),
		.mcand(mcand),
		.done(mul_done),
		.product(prod)
	);

	// first touch of the entry: the update itself and whether refill is due
	always_comb begin
		logic [DW-1:0] sum;
		logic [DW-1:0] el_n;
		ev_rec = rec_q;
		ev_st = 1'b0;
		ev_acct = 1'b0;
		ev_lwake = 1'b0;
		ev_scan = 1'b0;
		ev_refill = 1'b0;
		ev_ct = '0;
		ev_dt = '0;
		sum = '0;
		el_n = now_q - rec_q.last;
		if (mode_q == MODE_CREDIT || mode_q == MODE_DEBIT) begin
			if (!rec_q.flags[FL_ACTIVE] || value_q < 0) begin
				ev_st = 1'b1;
			end else if (value_q != 0) begin
				sum = {1'b0, (mode_q == MODE_CREDIT) ? rec_q.credit : rec_q.debit}
					+ DW'(value_q);
				if (mode_q == MODE_CREDIT) begin
					ev_rec.credit = sum[DW-1] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
				end else begin
					ev_rec.debit = sum[DW-1] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
				end
				ev_acct = 1'b1;
				ev_refill = (rec_q.period != 0) && (el_n > rec_q.period);
			end
		end else if (mode_q == MODE_SCAN) begin
			if (exceeded(rec_q)) begin
				ev_scan = 1'b1;
				ev_refill = (rec_q.period != 0) && (el_n >= rec_q.period);
			end
		end else if (mode_q == MODE_READ) begin
			if (!rec_q.flags[FL_ACTIVE]) begin
				ev_st = 1'b1;
			end else begin
				ev_ct = rec_q.credit;
				ev_dt = rec_q.debit;
			end
		end else if (mode_q >= MODE_SET_LIMIT && mode_q <= MODE_CB_REARM) begin
			if (!rec_q.flags[FL_ACTIVE]) begin
				ev_st = 1'b1;
			end else begin
				unique case (mode_q)
					MODE_SET_LIMIT: begin
						ev_rec.limit = value_q;
						ev_rec.last = '0;
						ev_rec.flags[FL_CALLED] = 1'b0;
						ev_lwake = 1'b1;
					end
					MODE_SET_PERIOD: ev_rec.period = DW'(value_q);
					MODE_SET_ACTION: begin
						ev_rec.flags[FL_BLOCK] = rec_q.flags[FL_BLOCK] | value_q[0];
						ev_rec.flags[FL_CALLBACK] = rec_q.flags[FL_CALLBACK] | value_q[1];
						ev_rec.flags[FL_ACTIVE] = rec_q.flags[FL_ACTIVE] | value_q[2];
					end
					MODE_CB_OFF: ev_rec.flags[FL_CALLBACK] = 1'b0;
					default: ev_rec.flags[FL_CALLED] = 1'b0;
				endcase
			end
		end
	end

	// refill from quotient, remainder and saturated product
	always_comb begin
		logic signed [DW-1:0] b;
		logic [DW-1:0] negb, mag;
		logic full;
		rf_rec = rec_q;
		rf_woke = 1'b0;
		b = bal_of(rec_q);
		negb = DW'(0) - DW'(b);
		mag = '0;
		full = 1'b0;
		if (!rec_q.limit[DW-1]) begin
			if (b <= 0) begin
				full = 1'b1;
				if (b < 0 || rec_q.limit > 0) begin
					rf_rec.debit = rec_q.credit;
				end
			end else if (rec_q.limit == 0) begin
				full = 1'b0;
			end else if (prod > (DW+1)'(b)) begin
				rf_rec.debit = rec_q.credit;
				full = 1'b1;
			end else begin
				rf_rec.debit = rec_q.debit + prod[CNT_W-1:0];
				full = (prod[DW-1:0] == DW'(b));
			end
		end else begin
			mag = (prod > (DW+1)'({1'b1, {(DW-1){1'b0}}})) ?
				{1'b1, {(DW-1){1'b0}}} : prod[DW-1:0];
			if (b < 0 && mag < negb) begin
				rf_rec.debit = rec_q.credit;
				full = 1'b1;
			end else begin
				full = (b < 0) && (mag == negb);
				rf_rec.debit = (mag >= {1'b0, rec_q.debit}) ? '0 :
					rec_q.debit - mag[CNT_W-1:0];
			end
		end
		rf_rec.last = full ? now_q : rec_q.last + (el - rem);
		if (!exceeded(rf_rec)) begin
			rf_rec.flags[FL_CALLED] = 1'b0;
			if (rf_rec.flags[FL_WAKE]) begin
				rf_rec.flags[FL_WAKE] = 1'b0;
				rf_woke = 1'b1;
			end
		end
	end

	// reporting actions after any refill
	always_comb begin
		po_rec = rec_q;
		po_notice = 1'b0;
		po_woke = woke_q;
		po_fire = 1'b0;
		po_blk = 1'b0;
		if (acct_q) begin
			if (exceeded(rec_q)) begin
				po_notice = rec_q.flags[FL_BLOCK] ||
					(!rec_q.flags[FL_CALLED] && rec_q.flags[FL_CALLBACK]);
			end else if (rec_q.flags[FL_WAKE]) begin
				po_rec.flags[FL_CALLED] = 1'b0;
				po_rec.flags[FL_WAKE] = 1'b0;
				po_woke = 1'b1;
			end
		end
		if (lwake_q && !exceeded(rec_q)) begin
			po_rec.flags[FL_CALLED] = 1'b0;
			if (rec_q.flags[FL_WAKE]) begin
				po_rec.flags[FL_WAKE] = 1'b0;
				po_woke = 1'b1;
			end
		end
		if (scan_q && exceeded(rec_q)) begin
			if (rec_q.flags[FL_BLOCK]) begin
				po_blk = 1'b1;
				po_rec.flags[FL_WAKE] = 1'b1;
			end
			if (rec_q.flags[FL_CALLBACK]) begin
				po_fire = !rec_q.flags[FL_CALLED];
				po_rec.flags[FL_CALLED] = 1'b1;
			end
		end
	end

	assign div_start = (state_q == ST_EVAL) && ev_refill;
	assign mul_start = (state_q == ST_DIV) && div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_acc) state_q <= oor ? ST_FIN : ST_RD;
				ST_RD: state_q <= ST_EVAL;
				ST_EVAL: state_q <= ev_refill ? ST_DIV : ST_POST;
				ST_DIV: if (div_done) state_q <= ST_MUL;
				ST_MUL: if (mul_done) state_q <= ST_REF;
				ST_REF: state_q <= ST_POST;
				ST_POST: state_q <= ST_FIN;
				default: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mode_q <= s_tuser;
				entry_q <= s_tdata[3:0];
				value_q <= s_tdata[67:4];
				now_q <= s_tdata[131:68];
				st_q <= oor;
				notice_q <= 1'b0;
				woke_q <= 1'b0;
				fire_q <= 1'b0;
				blk_q <= 1'b0;
				ct_q <= '0;
				dt_q <= '0;
				acct_q <= 1'b0;
				lwake_q <= 1'b0;
				scan_q <= 1'b0;
				rec_q <= '0;
			end
			ST_RD: rec_q <= rd_data;
			ST_EVAL: begin
				rec_q <= ev_rec;
				st_q <= ev_st;
				acct_q <= ev_acct;
				lwake_q <= ev_lwake;
				scan_q <= ev_scan;
				ct_q <= ev_ct;
				dt_q <= ev_dt;
			end
			ST_REF: begin
				rec_q <= rf_rec;
				woke_q <= rf_woke;
			end
			ST_POST: begin
				rec_q <= po_rec;
				notice_q <= po_notice;
				woke_q <= po_woke;
				fire_q <= po_fire;
				blk_q <= po_blk;
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {4'b0, dt_q, ct_q, bal_of(rec_q), blk_q, fire_q,
						woke_q, notice_q, exceeded(rec_q), st_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule
